// ===== sv/dna_pkg.sv =====
package dna_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 15;

  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int POS_W   = 8;
  localparam int RAD_W   = 4;
  localparam int DIM_W   = 9;
  localparam int COUNT_W = 10;
  // a mean of 8-bit values never exceeds 255
  localparam int QUOT_W  = CHAN_W;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

endpackage

// ===== sv/dna_div.sv =====
module dna_div import dna_pkg::*; #(
  parameter int DIVIDEND_W = 18,
  parameter int DIVISOR_W  = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [QUOT_W-1:0]     quotient,
  output logic                  done
);

  // dividend < divisor * 2**QUOT_W, so the remainder fits here
  localparam int PW = DIVISOR_W + QUOT_W;
  localparam int SW = $clog2(QUOT_W);

  logic          busy;
  logic [SW-1:0] step;
  logic [PW-1:0] rem;
  logic [PW-1:0] dsh;
  logic          ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == SW'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    // restoring division, one quotient bit per cycle
    if (start) begin
      rem <= PW'(dividend);
      dsh <= PW'(divisor) << (QUOT_W - 1);
    end else if (busy) begin
      if (ge) rem <= rem - dsh;
      dsh      <= dsh >> 1;
      quotient <= {quotient[QUOT_W-2:0], ge};
    end
  end

endmodule

// ===== sv/disc_neighbourhood_average.sv =====
// Disc neighbourhood average. Write requests (tuser kind 0) store one RGB pixel in an
// on-chip frame store of MAX_WIDTH x MAX_HEIGHT words when the position lies inside the
// frame. Query requests (kind 1) average each channel over the frame pixels inside the
// disc of the given radius (saturated to MAX_RADIUS) around the center. The scan visits
// one position of the disc's bounding square per cycle and reads the words inside disc
// and frame through the single read port, followed by the bit-serial divide. One request is in work
// at a time; a finished result waits in the output register while the next request is
// taken, and a query that finishes while that register is still full waits for it.
// Pixels never written read back as unknown. Frame width and height are written through
// the cfg port, which the user must do only while the block is idle (the block itself
// does not enforce this); they saturate to MAX_WIDTH and MAX_HEIGHT.
module disc_neighbourhood_average import dna_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x, pos_y, radius, red_in, green_in, blue_in, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // avg_red, avg_green, avg_blue, pixel_count, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int RUW    = $clog2(MAX_RADIUS + 1);
  localparam int RW     = RUW + 1;
  localparam int CW     = ((RW > POS_W) ? RW : POS_W) + 2;
  localparam int MAXCNT = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW     = $clog2(MAXCNT + 1);
  localparam int SUMW   = $clog2(MAXCNT * ((1 << CHAN_W) - 1) + 1);
  localparam int FW_RST = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
  localparam int FH_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
  localparam int PAD_W  = OUT_DATA_W - COUNT_W - 3 * CHAN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t state;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  // request fields
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [RAD_W-1:0]  radius;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic              accept;

  assign pos_x    = s_tdata[POS_W-1:0];
  assign pos_y    = s_tdata[2*POS_W-1:POS_W];
  assign radius   = s_tdata[2*POS_W+RAD_W-1:2*POS_W];
  assign red_in   = s_tdata[2*POS_W+RAD_W+CHAN_W-1:2*POS_W+RAD_W];
  assign green_in = s_tdata[2*POS_W+RAD_W+2*CHAN_W-1:2*POS_W+RAD_W+CHAN_W];
  assign blue_in  = s_tdata[2*POS_W+RAD_W+3*CHAN_W-1:2*POS_W+RAD_W+2*CHAN_W];

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(FW_RST);
      frame_height <= DIM_W'(FH_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:
          frame_width <= (int'(cfg_data) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_data;
        REG_FRAME_HEIGHT:
          frame_height <= (int'(cfg_data) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg_data;
        default: ;
      endcase
    end
  end

  // pixel write path
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign wr_en = accept && (s_tuser == KIND_WRITE) &&
                 ({1'b0, pos_x} < frame_width) && ({1'b0, pos_y} < frame_height);
  assign wr_addr = AW'(YW'(pos_y)) * AW'(MAX_WIDTH) + AW'(XW'(pos_x));

  // disc scan state
  logic [RUW-1:0]       rad;
  logic [2*RUW-1:0]     lim;
  logic [POS_W-1:0]     cx;
  logic [POS_W-1:0]     cy;
  logic signed [RW-1:0] dx;
  logic signed [RW-1:0] dy;
  logic [RUW-1:0]       rad_in;

  assign rad_in = (int'(radius) > MAX_RADIUS) ? RUW'(MAX_RADIUS) : RUW'(radius);

  logic [RUW-1:0]        adx;
  logic [RUW-1:0]        ady;
  logic [2*RUW-1:0]      adx2;
  logic [2*RUW-1:0]      ady2;
  logic [2*RUW:0]        dist2;
  logic signed [CW-1:0]  vx;
  logic signed [CW-1:0]  vy;
  logic                  in_disc;
  logic                  in_frame;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic signed [RW-1:0]  rad_s;
  logic                  row_end;

  assign rad_s = $signed({1'b0, rad});
  assign adx   = dx[RW-1] ? RUW'(-dx) : RUW'(dx);
  assign ady   = dy[RW-1] ? RUW'(-dy) : RUW'(dy);
  assign adx2  = adx * adx;
  assign ady2  = ady * ady;
  assign dist2 = {1'b0, adx2} + {1'b0, ady2};
  assign in_disc = (dist2 <= {1'b0, lim});

  assign vx = CW'($signed({1'b0, cx})) + CW'(dx);
  assign vy = CW'($signed({1'b0, cy})) + CW'(dy);
  assign in_frame = !vx[CW-1] && !vy[CW-1] &&
                    ($unsigned(vx) < CW'(frame_width)) && ($unsigned(vy) < CW'(frame_height));

  assign rd_en   = (state == S_SCAN) && in_disc && in_frame;
  assign rd_addr = AW'(YW'($unsigned(vy))) * AW'(MAX_WIDTH) + AW'(XW'($unsigned(vx)));
  assign row_end = (dx == rad_s);

  // frame store, one write and one registered read port
  logic [PIXEL_W-1:0] frame_store [DEPTH];
  logic [PIXEL_W-1:0] rd_word;
  logic               rd_pend;

  always_ff @(posedge clk) begin
    if (wr_en) frame_store[wr_addr] <= {red_in, green_in, blue_in};
    if (rd_en) rd_word <= frame_store[rd_addr];
  end

  // accumulators and divide
  logic [SUMW-1:0]   sum_r;
  logic [SUMW-1:0]   sum_g;
  logic [SUMW-1:0]   sum_b;
  logic [NW-1:0]     cnt;
  logic              div_start;
  logic [QUOT_W-1:0] q_r;
  logic [QUOT_W-1:0] q_g;
  logic [QUOT_W-1:0] q_b;
  logic              done_r;
  logic              done_g;
  logic              done_b;

  assign div_start = (state == S_DIV_START);

  dna_div #(.DIVIDEND_W(SUMW), .DIVISOR_W(NW)) u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_r), .divisor(cnt),
    .quotient(q_r), .done(done_r)
  );

  dna_div #(.DIVIDEND_W(SUMW), .DIVISOR_W(NW)) u_div_g (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_g), .divisor(cnt),
    .quotient(q_g), .done(done_g)
  );

  dna_div #(.DIVIDEND_W(SUMW), .DIVISOR_W(NW)) u_div_b (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_b), .divisor(cnt),
    .quotient(q_b), .done(done_b)
  );

  logic cnt_zero;
  assign cnt_zero = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      // load the output register when it is empty or being taken
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (s_tuser == KIND_QUERY)) state <= S_SCAN;
        end
        S_SCAN: begin
          if (row_end && (dy == rad_s)) state <= S_DRAIN;
        end
        S_DRAIN:     state <= S_DIV_START;
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (done_r && done_g && done_b) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end

    if (accept) begin
      cx    <= pos_x;
      cy    <= pos_y;
      rad   <= rad_in;
      lim   <= rad_in * rad_in;
      dx    <= -$signed({1'b0, rad_in});
      dy    <= -$signed({1'b0, rad_in});
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      cnt   <= '0;
    end else begin
      if (state == S_SCAN) begin
        if (row_end) begin
          dx <= -rad_s;
          dy <= dy + 1'b1;
        end else begin
          dx <= dx + 1'b1;
        end
      end
      // read data lands in the cycle after the address
      if (rd_pend) begin
        sum_r <= sum_r + SUMW'(rd_word[3*CHAN_W-1:2*CHAN_W]);
        sum_g <= sum_g + SUMW'(rd_word[2*CHAN_W-1:CHAN_W]);
        sum_b <= sum_b + SUMW'(rd_word[CHAN_W-1:0]);
        cnt   <= cnt + 1'b1;
      end
    end

    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {PAD_W'(0), COUNT_W'(cnt),
                  cnt_zero ? CHAN_W'(0) : q_b,
                  cnt_zero ? CHAN_W'(0) : q_g,
                  cnt_zero ? CHAN_W'(0) : q_r};
    end
  end

endmodule
